// ----- rtl/gi2d_pkg.sv -----
// ----------------------------------------------------------------------------
// gi2d_pkg: shared definitions for the 2D grid integrator
// Holds default sizes, field widths, command and register codes, the
// controller state type and the saturation limits of the accumulator.
// ----------------------------------------------------------------------------
package gi2d_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FRAC_BITS   = 16;
    localparam int MUL_DIGIT   = 16;
    localparam int COUNT_W     = 9;
    localparam int INDEX_W     = 8;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int ACC_W       = 64;
    localparam int MIN_POINTS  = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_X = 2'd0,
        CMD_LOAD_Y = 2'd1,
        CMD_SAMPLE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_COUNT = 1'b0,
        CFG_Y_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_DIFF,
        ST_MUL,
        ST_SCALE,
        ST_TERM,
        ST_ACC,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/gi2d_coord_mem.sv -----
// ----------------------------------------------------------------------------
// gi2d_coord_mem: coordinate memory
// Synchronous memory with one write port and one read port. Read data is
// registered and appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module gi2d_coord_mem #(
    parameter int DEPTH = gi2d_pkg::MAX_POINTS_DEF,
    parameter int WIDTH = gi2d_pkg::VALUE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/gi2d_mul.sv -----
// ----------------------------------------------------------------------------
// gi2d_mul: three-operand magnitude multiplier
// Forms x*y*z of unsigned operands with one shared multiplier that takes
// one 16-bit digit of the second operand per cycle, most significant first.
// The first pass forms x*y, the second pass multiplies that by z.
// ----------------------------------------------------------------------------
module gi2d_mul #(
    parameter int VALUE_BITS = gi2d_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] op_x,
    input  logic [VALUE_BITS-1:0] op_y,
    input  logic [VALUE_BITS-1:0] op_z,
    output logic                  done,
    output logic [2*VALUE_BITS + ((VALUE_BITS + gi2d_pkg::MUL_DIGIT - 1)
                  / gi2d_pkg::MUL_DIGIT) * gi2d_pkg::MUL_DIGIT - 1:0] product
);

    import gi2d_pkg::*;

    localparam int ND  = (VALUE_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BW  = ND * MUL_DIGIT;
    localparam int AW2 = 2 * VALUE_BITS;
    localparam int PPW = AW2 + MUL_DIGIT;
    localparam int PW  = AW2 + BW;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;

    logic                  busy_reg;
    logic                  phase_reg;
    logic [CW-1:0]         cnt_reg;
    logic [AW2-1:0]        a_reg;
    logic [BW-1:0]         b_reg;
    logic [VALUE_BITS-1:0] z_reg;
    logic [PW-1:0]         acc_reg;

    logic [MUL_DIGIT-1:0]  digit;
    logic [PPW-1:0]        partial;
    logic [PW-1:0]         acc_sum;
    logic                  last_digit;

    assign digit      = b_reg[BW-1 -: MUL_DIGIT];
    assign partial    = PPW'(a_reg) * PPW'(digit);
    assign acc_sum    = (acc_reg << MUL_DIGIT) + PW'(partial);
    assign last_digit = (cnt_reg == CW'(ND - 1));
    assign done       = busy_reg && phase_reg && last_digit;
    assign product    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (last_digit)
            begin
                cnt_reg <= '0;
                if (phase_reg)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    phase_reg <= 1'b1;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= AW2'(op_x);
            b_reg   <= BW'(op_y);
            z_reg   <= op_z;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (last_digit && !phase_reg)
            begin
                a_reg   <= acc_sum[AW2-1:0];
                b_reg   <= BW'(z_reg);
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_sum;
                b_reg   <= b_reg << MUL_DIGIT;
            end
        end
    end

endmodule

// ----- rtl/grid_integral_2d.sv -----
// ----------------------------------------------------------------------------
// grid_integral_2d: two-dimensional trapezoid integration on a grid
// Loads x and y grid coordinates into two memories, then weights each z
// sample by the trapezoid weights of its row and column and sums the terms
// in a saturating Q32.32 accumulator that is emitted on the last sample.
// ----------------------------------------------------------------------------
// Loads and unused commands are taken in the idle state. A z sample inside the grid passes
// through the read, difference, multiply, scale, term and accumulate states before the next accept,
// set by two sequential reads per coordinate memory and the 16-bit digit multiplier; one outside
// the grid skips multiply, scale and term. A last sample adds the emit state, held while the output stalls.
// Reset clears the sum, the overflow flag and the output valid, sets both counts to 2
// and leaves the coordinate memories unwritten.
module grid_integral_2d #(
    parameter int MAX_POINTS = gi2d_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = gi2d_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gi2d_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gi2d_pkg::COUNT_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gi2d_pkg::CMD_W-1:0]          cmd,
    input  logic [gi2d_pkg::INDEX_W-1:0]        row_index,
    input  logic [gi2d_pkg::INDEX_W-1:0]        col_index,
    input  logic signed [VALUE_BITS-1:0]        value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gi2d_pkg::ACC_W-1:0]   integral,
    output logic                                overflow
);

    import gi2d_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NW   = ($clog2(MAX_POINTS + 1) > COUNT_W) ? $clog2(MAX_POINTS + 1) : COUNT_W;
    localparam int ND   = (VALUE_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int PW   = 2 * VALUE_BITS + ND * MUL_DIGIT;
    localparam int QW   = PW - FRAC_BITS;
    localparam int QRW  = QW + 1;
    localparam int EXTW = (QRW > ACC_W + 1) ? QRW : ACC_W + 1;

    state_t state_reg;
    state_t state_next;

    logic [COUNT_W-1:0]    x_count_reg;
    logic [COUNT_W-1:0]    x_count_next;
    logic [COUNT_W-1:0]    y_count_reg;
    logic [COUNT_W-1:0]    y_count_next;
    logic [ACC_W-1:0]      sum_reg;
    logic [ACC_W-1:0]      sum_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ACC_W-1:0]      integral_reg;
    logic                  overflow_reg;

    logic [AW-1:0]         ax_reg;
    logic [AW-1:0]         ay_reg;
    logic [VALUE_BITS-1:0] z_reg;
    logic                  last_reg;
    logic                  in_grid_reg;
    logic [1:0]            edges_reg;
    logic [VALUE_BITS-1:0] xa_reg;
    logic [VALUE_BITS-1:0] ya_reg;
    logic                  neg_reg;
    logic [QW-1:0]         q_reg;
    logic                  round_reg;
    logic [ACC_W-1:0]      term_reg;
    logic                  term_sat_reg;

    logic                  in_accept;
    logic                  mem_rd;
    logic                  rd_b;
    logic                  mul_start;
    logic                  mul_done;
    logic                  emit_go;

    logic [NW-1:0]         nx_eff;
    logic [NW-1:0]         ny_eff;
    logic [NW-1:0]         row_n;
    logic [NW-1:0]         col_n;
    logic                  edge_x;
    logic                  edge_y;
    logic                  in_grid;
    logic [1:0]            edges;
    logic                  x_we;
    logic                  y_we;
    logic [AW-1:0]         ax_in;
    logic [AW-1:0]         ay_in;
    logic [AW-1:0]         x_raddr;
    logic [AW-1:0]         y_raddr;
    logic [VALUE_BITS-1:0] x_rdata;
    logic [VALUE_BITS-1:0] y_rdata;

    logic [VALUE_BITS:0]   dx;
    logic [VALUE_BITS:0]   dy;
    logic [VALUE_BITS:0]   dx_neg;
    logic [VALUE_BITS:0]   dy_neg;
    logic [VALUE_BITS:0]   zx;
    logic [VALUE_BITS:0]   zx_neg;
    logic [VALUE_BITS-1:0] mag_x;
    logic [VALUE_BITS-1:0] mag_y;
    logic [VALUE_BITS-1:0] mag_z;
    logic                  neg;

    logic [PW-1:0]         product;
    logic [QW-1:0]         q_scaled;
    logic                  lost;
    logic [QRW-1:0]        qr;
    logic [EXTW-1:0]       qe;
    logic [EXTW-1:0]       half_range;
    logic                  fits;
    logic [ACC_W-1:0]      term_next;
    logic [ACC_W-1:0]      sum_add;
    logic                  add_ovf;

    // Effective counts and sample position at the input.
    always_comb
    begin
        nx_eff = NW'(x_count_reg);
        ny_eff = NW'(y_count_reg);
        if (nx_eff < NW'(MIN_POINTS))
        begin
            nx_eff = NW'(MIN_POINTS);
        end
        else if (nx_eff > NW'(MAX_POINTS))
        begin
            nx_eff = NW'(MAX_POINTS);
        end
        if (ny_eff < NW'(MIN_POINTS))
        begin
            ny_eff = NW'(MIN_POINTS);
        end
        else if (ny_eff > NW'(MAX_POINTS))
        begin
            ny_eff = NW'(MAX_POINTS);
        end
    end

    assign row_n   = NW'(row_index);
    assign col_n   = NW'(col_index);
    assign edge_x  = (row_index == '0) || (row_n == nx_eff - NW'(1));
    assign edge_y  = (col_index == '0) || (col_n == ny_eff - NW'(1));
    assign edges   = {1'b0, edge_x} + {1'b0, edge_y};
    assign in_grid = (row_n < nx_eff) && (col_n < ny_eff);

    assign in_accept = in_valid && !in_stall;
    assign x_we = in_accept && (cmd == CMD_LOAD_X) && (row_n < NW'(MAX_POINTS));
    assign y_we = in_accept && (cmd == CMD_LOAD_Y) && (col_n < NW'(MAX_POINTS));

    // The interior weight reads entries i and i-1; the first index uses 1 and 0.
    assign ax_in   = (row_index == '0) ? AW'(1) : AW'(row_index);
    assign ay_in   = (col_index == '0) ? AW'(1) : AW'(col_index);
    assign x_raddr = rd_b ? (ax_reg - AW'(1)) : ax_in;
    assign y_raddr = rd_b ? (ay_reg - AW'(1)) : ay_in;

    gi2d_coord_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (VALUE_BITS)
    ) u_x_mem (
        .clk     (clk),
        .wr_en   (x_we),
        .wr_addr (AW'(row_index)),
        .wr_data (value),
        .rd_en   (mem_rd),
        .rd_addr (x_raddr),
        .rd_data (x_rdata)
    );

    gi2d_coord_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (VALUE_BITS)
    ) u_y_mem (
        .clk     (clk),
        .wr_en   (y_we),
        .wr_addr (AW'(col_index)),
        .wr_data (value),
        .rd_en   (mem_rd),
        .rd_addr (y_raddr),
        .rd_data (y_rdata)
    );

    // Differences and magnitudes of the weights and the sample.
    always_comb
    begin
        dx     = {xa_reg[VALUE_BITS-1], xa_reg} - {x_rdata[VALUE_BITS-1], x_rdata};
        dy     = {ya_reg[VALUE_BITS-1], ya_reg} - {y_rdata[VALUE_BITS-1], y_rdata};
        zx     = {z_reg[VALUE_BITS-1], z_reg};
        dx_neg = -dx;
        dy_neg = -dy;
        zx_neg = -zx;
        mag_x  = VALUE_BITS'(dx[VALUE_BITS] ? dx_neg : dx);
        mag_y  = VALUE_BITS'(dy[VALUE_BITS] ? dy_neg : dy);
        mag_z  = VALUE_BITS'(zx[VALUE_BITS] ? zx_neg : zx);
        neg    = dx[VALUE_BITS] ^ dy[VALUE_BITS] ^ zx[VALUE_BITS];
    end

    gi2d_mul #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_x    (mag_x),
        .op_y    (mag_y),
        .op_z    (mag_z),
        .done    (mul_done),
        .product (product)
    );

    // Scaling by 2^-(16+k) rounds the signed term toward minus infinity.
    assign q_scaled = QW'(product >> (FRAC_BITS + int'(edges_reg)));
    assign lost     = (product[FRAC_BITS-1:0] != '0)
                   || ((edges_reg != 2'd0) && product[FRAC_BITS])
                   || ((edges_reg == 2'd2) && product[FRAC_BITS+1]);

    always_comb
    begin
        qr         = QRW'(q_reg) + QRW'(round_reg);
        qe         = EXTW'(qr);
        half_range = EXTW'(1) << (ACC_W - 1);
        fits       = neg_reg ? (qe <= half_range) : (qe < half_range);
        if (!fits)
        begin
            term_next = neg_reg ? ACC_MIN : ACC_MAX;
        end
        else if (neg_reg)
        begin
            term_next = -qe[ACC_W-1:0];
        end
        else
        begin
            term_next = qe[ACC_W-1:0];
        end
    end

    assign sum_add = sum_reg + term_reg;
    assign add_ovf = (sum_reg[ACC_W-1] == term_reg[ACC_W-1])
                  && (sum_add[ACC_W-1] != sum_reg[ACC_W-1]);

    // Controller outputs.
    always_comb
    begin
        in_stall  = 1'b1;
        mem_rd    = 1'b0;
        rd_b      = 1'b0;
        mul_start = 1'b0;
        emit_go   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                mem_rd   = in_valid && (cmd == CMD_SAMPLE);
            end
            ST_READ_B:
            begin
                mem_rd = 1'b1;
                rd_b   = 1'b1;
            end
            ST_DIFF:
            begin
                mul_start = in_grid_reg;
            end
            ST_EMIT:
            begin
                emit_go = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_SAMPLE))
                begin
                    state_next = ST_READ_B;
                end
            end
            ST_READ_B:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = in_grid_reg ? ST_MUL : ST_ACC;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_count_next = x_count_reg;
        y_count_next = y_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_X_COUNT: x_count_next = cfg_data;
                CFG_Y_COUNT: y_count_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        sum_next       = sum_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == ST_ACC)
        begin
            sum_next  = add_ovf ? (sum_reg[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_add;
            flag_next = flag_reg || term_sat_reg || add_ovf;
        end
        if (emit_go)
        begin
            sum_next       = '0;
            flag_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_count_reg   <= COUNT_W'(MIN_POINTS);
            y_count_reg   <= COUNT_W'(MIN_POINTS);
            sum_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_count_reg   <= x_count_next;
            y_count_reg   <= y_count_next;
            sum_reg       <= sum_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (cmd == CMD_SAMPLE))
        begin
            ax_reg      <= ax_in;
            ay_reg      <= ay_in;
            z_reg       <= value;
            last_reg    <= last;
            in_grid_reg <= in_grid;
            edges_reg   <= edges;
        end
        if (state_reg == ST_READ_B)
        begin
            xa_reg <= x_rdata;
            ya_reg <= y_rdata;
        end
        if (state_reg == ST_DIFF)
        begin
            neg_reg      <= neg;
            term_reg     <= '0;
            term_sat_reg <= 1'b0;
        end
        if (state_reg == ST_SCALE)
        begin
            q_reg     <= q_scaled;
            round_reg <= neg_reg && lost;
        end
        if (state_reg == ST_TERM)
        begin
            term_reg     <= term_next;
            term_sat_reg <= !fits;
        end
        if (emit_go)
        begin
            integral_reg <= sum_reg;
            overflow_reg <= flag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign integral  = integral_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTHESIS
    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("Multiplier finished outside the multiply state.");

    a_emit_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (out_valid_reg && (sum_reg == '0) && !flag_reg))
        else $error("Emitting an item did not clear the accumulator.");

    a_outside_adds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIFF) && !in_grid_reg) |=> ((state_reg == ST_ACC) && (term_reg == '0)))
        else $error("A sample outside the grid produced a nonzero term.");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (x_we || y_we) |-> (state_reg == ST_IDLE))
        else $error("Coordinate write while a sample is in progress.");
`endif

endmodule
